>>> design/blids_pkg.sv
// ----------------------------------------------------------------------------
// Bounded list core package
// Shared types, codes and widths for the bounded list insert/delete/search core.
// ----------------------------------------------------------------------------
`default_nettype none

package blids_pkg;

    localparam int unsigned DEPTH_DEF = 16;   // default list capacity
    localparam int unsigned DATA_W    = 32;   // width of one list entry
    localparam int unsigned OP_W      = 3;    // operation code width
    localparam int unsigned CNT_W     = 5;    // result count field width
    localparam int unsigned ST_W      = 2;    // result status field width
    localparam int unsigned M_DATA_W  = 8;    // count and status, padded to a byte

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_LENGTH     = 3'd2,
        OP_COUNT      = 3'd3,
        OP_POP_FRONT  = 3'd4,
        OP_POP_BACK   = 3'd5,
        OP_REMOVE     = 3'd6
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_DONE
    } state_t;

    // Control from the sequencer to the compare unit
    typedef struct packed {
        logic load;   // latch the search key, clear the match count
        logic step;   // compare the current entry, accumulate a hit
    } cmp_ctl_t;

endpackage : blids_pkg

`default_nettype wire

>>> design/bounded_list_insert_delete_search_core.sv
// ----------------------------------------------------------------------------
// Bounded list insert/delete/search core
// Ordered list of signed 32-bit values in a circular RAM, driven by a small
// sequencer and one shared compare unit.
// ----------------------------------------------------------------------------
// The list holds up to DEPTH signed 32-bit values, front first, and comes out
// of reset empty. Each input beat carries an operation code on s_tuser and a
// value on s_tdata; each one gives exactly one result beat with a count and a
// status. The values sit in a circular buffer in a single RAM with one read
// and one write port, so front and back inserts and removals only move the
// head pointer or the length (an insert also writes one entry) and go from
// accept straight to the done step. Count-matches walks the list through the
// RAM read port and the shared comparator, a read and a compare per entry.
// Remove-first-match scans the same way up to the match at position k, then
// closes the gap with one read and one write per moved entry. The registered
// RAM read data is why each entry takes a read step before its compare or
// write step. The result sits in an output register, so the next beat is
// taken while a result still waits for m_tready; the result after that holds
// in the done step until the register is taken. The count field is the low
// 5 bits of the true count when DEPTH exceeds 31.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_list_insert_delete_search_core #(
    parameter int unsigned DEPTH = blids_pkg::DEPTH_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // input channel
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [blids_pkg::DATA_W-1:0]    s_tdata,  // [31:0] value (signed)
    input  wire logic [blids_pkg::OP_W-1:0]      s_tuser,  // [2:0] op
    // result channel
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic      [blids_pkg::M_DATA_W-1:0]  m_tdata   // [4:0] count, [6:5] status, [7] 0
);

    import blids_pkg::*;

    localparam int unsigned AW = $clog2(DEPTH);          // RAM address
    localparam int unsigned LW = $clog2(DEPTH + 1);      // length, 0..DEPTH
    localparam int unsigned SW = $clog2(2 * DEPTH);      // head + length
    localparam int unsigned XW = (LW > CNT_W) ? LW : CNT_W;

    // ------------------------------------------------------------------
    // Pointer helpers: wrap within DEPTH entries
    // ------------------------------------------------------------------
    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        ptr_inc = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
        ptr_dec = (p == '0) ? AW'(DEPTH - 1) : p - AW'(1);
    endfunction

    function automatic logic [AW-1:0] ptr_add(input logic [AW-1:0] h,
                                              input logic [LW-1:0] l);
        logic [SW-1:0] s;
        s = SW'(h) + SW'(l);
        if (s >= SW'(DEPTH)) begin
            s = s - SW'(DEPTH);
        end
        ptr_add = s[AW-1:0];
    endfunction

    // truncate or extend a list count to the result field
    function automatic logic [CNT_W-1:0] to_cnt(input logic [LW-1:0] c);
        logic [XW-1:0] t;
        t = XW'(c);
        to_cnt = t[CNT_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    state_t         state_reg,   state_next;
    op_t            op_reg,      op_next;
    logic [AW-1:0]  head_reg,    head_next;    // physical slot of the front
    logic [LW-1:0]  len_reg,     len_next;
    logic [LW-1:0]  idx_reg,     idx_next;     // logical position under work
    logic [AW-1:0]  ptr_reg,     ptr_next;     // physical slot of idx_reg
    logic [LW-1:0]  res_cnt_reg, res_cnt_next;
    status_t        res_st_reg,  res_st_next;
    logic           m_valid_reg, m_valid_next;
    logic [CNT_W-1:0] m_cnt_reg, m_cnt_next;
    status_t        m_st_reg,    m_st_next;

    // RAM and compare unit hookup
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [DATA_W-1:0] ram_rdata;
    cmp_ctl_t          cmp_ctl;
    logic              cmp_hit;
    logic [LW-1:0]     cmp_total;

    logic              last_entry;

    blids_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    blids_cmp #(
        .CW (LW)
    ) u_cmp (
        .aclk    (aclk),
        .ctl     (cmp_ctl),
        .key_in  (s_tdata),
        .data_in (ram_rdata),
        .hit     (cmp_hit),
        .total   (cmp_total)
    );

    assign s_tready   = (state_reg == S_IDLE);
    assign last_entry = ((idx_reg + LW'(1)) == len_reg);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        head_next    = head_reg;
        len_next     = len_reg;
        idx_next     = idx_reg;
        ptr_next     = ptr_reg;
        res_cnt_next = res_cnt_reg;
        res_st_next  = res_st_reg;
        m_cnt_next   = m_cnt_reg;
        m_st_next    = m_st_reg;
        // drop the output beat once taken
        m_valid_next = m_valid_reg & ~m_tready;

        ram_we    = 1'b0;
        ram_waddr = head_reg;
        ram_wdata = s_tdata;
        ram_raddr = ptr_reg;
        cmp_ctl   = '0;

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next     = op_t'(s_tuser);
                    state_next  = S_DONE;
                    res_cnt_next = len_reg;
                    res_st_next  = ST_OK;
                    case (op_t'(s_tuser))
                        OP_PUSH_FRONT: begin
                            if (len_reg == LW'(DEPTH)) begin
                                res_st_next = ST_FULL;
                            end else begin
                                head_next    = ptr_dec(head_reg);
                                ram_we       = 1'b1;
                                ram_waddr    = ptr_dec(head_reg);
                                len_next     = len_reg + LW'(1);
                                res_cnt_next = len_reg + LW'(1);
                            end
                        end
                        OP_PUSH_BACK: begin
                            if (len_reg == LW'(DEPTH)) begin
                                res_st_next = ST_FULL;
                            end else begin
                                ram_we       = 1'b1;
                                ram_waddr    = ptr_add(head_reg, len_reg);
                                len_next     = len_reg + LW'(1);
                                res_cnt_next = len_reg + LW'(1);
                            end
                        end
                        OP_LENGTH: begin
                            res_cnt_next = len_reg;
                        end
                        OP_COUNT: begin
                            // an empty list counts zero at once
                            if (len_reg != '0) begin
                                cmp_ctl.load = 1'b1;
                                idx_next     = '0;
                                ptr_next     = head_reg;
                                state_next   = S_SCAN_RD;
                            end
                        end
                        OP_POP_FRONT: begin
                            if (len_reg == '0) begin
                                res_st_next = ST_EMPTY;
                            end else begin
                                head_next    = ptr_inc(head_reg);
                                len_next     = len_reg - LW'(1);
                                res_cnt_next = len_reg - LW'(1);
                            end
                        end
                        OP_POP_BACK: begin
                            if (len_reg == '0) begin
                                res_st_next = ST_EMPTY;
                            end else begin
                                len_next     = len_reg - LW'(1);
                                res_cnt_next = len_reg - LW'(1);
                            end
                        end
                        OP_REMOVE: begin
                            if (len_reg == '0) begin
                                res_st_next = ST_EMPTY;
                            end else begin
                                cmp_ctl.load = 1'b1;
                                idx_next     = '0;
                                ptr_next     = head_reg;
                                state_next   = S_SCAN_RD;
                            end
                        end
                        default: begin
                            // unused code: leave the list alone, report length
                            res_cnt_next = len_reg;
                        end
                    endcase
                end
            end

            S_SCAN_RD: begin
                ram_raddr  = ptr_reg;
                state_next = S_SCAN_CMP;
            end

            S_SCAN_CMP: begin
                cmp_ctl.step = 1'b1;
                if (op_reg == OP_COUNT) begin
                    if (last_entry) begin
                        res_cnt_next = cmp_total;
                        res_st_next  = ST_OK;
                        state_next   = S_DONE;
                    end else begin
                        idx_next   = idx_reg + LW'(1);
                        ptr_next   = ptr_inc(ptr_reg);
                        state_next = S_SCAN_RD;
                    end
                end else if (cmp_hit) begin
                    if (last_entry) begin
                        // match at the back: no gap to close
                        len_next     = len_reg - LW'(1);
                        res_cnt_next = len_reg - LW'(1);
                        res_st_next  = ST_OK;
                        state_next   = S_DONE;
                    end else begin
                        state_next = S_SHIFT_RD;
                    end
                end else if (last_entry) begin
                    res_cnt_next = len_reg;
                    res_st_next  = ST_NOTFOUND;
                    state_next   = S_DONE;
                end else begin
                    idx_next   = idx_reg + LW'(1);
                    ptr_next   = ptr_inc(ptr_reg);
                    state_next = S_SCAN_RD;
                end
            end

            S_SHIFT_RD: begin
                // fetch the successor of the slot being filled
                ram_raddr  = ptr_inc(ptr_reg);
                state_next = S_SHIFT_WR;
            end

            S_SHIFT_WR: begin
                ram_we    = 1'b1;
                ram_waddr = ptr_reg;
                ram_wdata = ram_rdata;
                if ((idx_reg + LW'(2)) == len_reg) begin
                    len_next     = len_reg - LW'(1);
                    res_cnt_next = len_reg - LW'(1);
                    res_st_next  = ST_OK;
                    state_next   = S_DONE;
                end else begin
                    idx_next   = idx_reg + LW'(1);
                    ptr_next   = ptr_inc(ptr_reg);
                    state_next = S_SHIFT_RD;
                end
            end

            S_DONE: begin
                // hold until the output register is free or being emptied
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_cnt_next   = to_cnt(res_cnt_reg);
                    m_st_next    = res_st_reg;
                    state_next   = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            head_reg    <= '0;
            len_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            len_reg     <= len_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload and cursor registers
    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        idx_reg     <= idx_next;
        ptr_reg     <= ptr_next;
        res_cnt_reg <= res_cnt_next;
        res_st_reg  <= res_st_next;
        m_cnt_reg   <= m_cnt_next;
        m_st_reg    <= m_st_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_st_reg, m_cnt_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= LW'(DEPTH))
        else $error("list length exceeds capacity");

    a_head_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        head_reg <= AW'(DEPTH - 1))
        else $error("head pointer out of range");

    a_shift_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SHIFT_WR) |-> (len_reg >= LW'(2)))
        else $error("gap close with fewer than two entries");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result beat raised outside the done step");

    a_len_stable_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN_RD || state_reg == S_SHIFT_RD) |=> $stable(len_reg))
        else $error("length changed in the middle of a walk");

endmodule : bounded_list_insert_delete_search_core

`default_nettype wire

>>> design/blids_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module blids_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule : blids_ram

`default_nettype wire

>>> design/blids_cmp.sv
// ----------------------------------------------------------------------------
// Shared compare unit
// Holds the search key, compares one entry per step and counts the hits.
// ----------------------------------------------------------------------------
`default_nettype none

module blids_cmp #(
    parameter int unsigned CW = 5
) (
    input  wire logic                          aclk,
    input  wire blids_pkg::cmp_ctl_t           ctl,
    input  wire logic [blids_pkg::DATA_W-1:0]  key_in,
    input  wire logic [blids_pkg::DATA_W-1:0]  data_in,
    output logic                               hit,
    output logic      [CW-1:0]                 total
);

    import blids_pkg::*;

    logic [DATA_W-1:0] key_reg;
    logic [CW-1:0]     cnt_reg;

    assign hit   = (data_in == key_reg);
    // running total including the entry under compare now
    assign total = cnt_reg + CW'(hit);

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            key_reg <= key_in;
            cnt_reg <= '0;
        end else if (ctl.step) begin
            cnt_reg <= total;
        end
    end

endmodule : blids_cmp

`default_nettype wire
